[rtl/assert_macros.svh]
// assertion macros used by the checker file bmv_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BMV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define BMV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/bmv_pkg.sv]
// constants, codes and types of the boxcar mean / variance filter
// no dependencies
package bmv_pkg;

  localparam int MAX_SAMPLES = 2048;
  localparam int COL_W       = $clog2(MAX_SAMPLES);
  localparam int LEN_W       = COL_W + 1;
  localparam int PIX_W       = 16;
  localparam int SUM_W       = 21;
  localparam int SQ_W        = 35;
  localparam int CNT_W       = 4;
  localparam int WSUM_W      = 24;
  localparam int WSQ_W       = 39;
  localparam int WCNT_W      = 8;
  localparam int VAR_W       = 38;
  localparam int ENTRY_W     = SUM_W + SQ_W + CNT_W;
  localparam int PROD_W      = WSQ_W + WCNT_W;
  localparam int DVD_W       = 56;
  localparam int DVS_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIXELS  = 3'd5;

  localparam logic signed [WSUM_W-1:0] AVG_HI = 24'sd8388352;
  localparam logic signed [WSUM_W-1:0] AVG_LO = -24'sd8388608;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

[rtl/bmv_if.sv]
// item channels of the filter: input items and result items
// depends on bmv_pkg
interface bmv_in_if;
  import bmv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [COL_W-1:0]        column;
  logic signed [PIX_W-1:0] pixel;
  logic                    pixel_special;
  modport source (output valid, operation, column, pixel, pixel_special, input ready);
  modport sink (input valid, operation, column, pixel, pixel_special, output ready);
endinterface

interface bmv_out_if;
  import bmv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [WCNT_W-1:0]        valid_count;
  logic signed [WSUM_W-1:0] average;
  logic                     average_ok;
  logic [VAR_W-1:0]         variance;
  logic                     variance_ok;
  modport source (output valid, valid_count, average, average_ok, variance, variance_ok,
                  input ready);
  modport sink (input valid, valid_count, average, average_ok, variance, variance_ok,
                output ready);
endinterface

[rtl/bmv_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

[rtl/bmv_div.sv]
// restoring divider, one quotient bit per cycle
// depends on bmv_pkg
module bmv_div import bmv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);
  localparam int STEP_W = $clog2(DVD_W);

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    rem_q, rem_d, trial;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic              fits;

  always_comb begin
    trial = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? trial - {1'b0, dvs_q} : trial;
    dvd_d = {dvd_q[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

[rtl/boxcar_mean_variance_filter.sv]
// top level of the boxcar mean / variance filter
// depends on bmv_pkg, bmv_if, bmv_ram, bmv_div
// After reset the block sweeps its 2048-entry column ram to zero with ready low;
// configuration writes are taken during that time. Each column entry keeps the
// sum, sum of squares and count of its accepted pixels. An add or remove item with an
// accepted pixel updates its column entry (ram read, then write back). A query item reads
// the 2*half_width+1 mirrored columns one per cycle, then runs a shift-add multiply and
// up to two serial divisions for the mean and the variance; its result waits in an
// output register while the next item is taken.
module boxcar_mean_variance_filter import bmv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bmv_in_if.sink                in_i,
  bmv_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);
  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_UPD   = 8'b0000_0100,
    ST_ACC   = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_DIVA  = 8'b0010_0000,
    ST_DIVV  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q;

  // configuration
  logic [11:0]             line_length_q;
  logic [2:0]              half_width_q, half_height_q;
  logic signed [PIX_W-1:0] min_valid_q, max_valid_q;
  logic [7:0]              min_pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= 12'd2048;
      half_width_q  <= 3'd1;
      half_height_q <= 3'd1;
      min_valid_q   <= -16'sd32768;
      max_valid_q   <= 16'sd32767;
      min_pixels_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_LENGTH: line_length_q <= cfg_wdata_i[11:0];
        CFG_HALF_WIDTH:  half_width_q  <= cfg_wdata_i[2:0];
        CFG_HALF_HEIGHT: half_height_q <= cfg_wdata_i[2:0];
        CFG_MIN_VALID:   min_valid_q   <= $signed(cfg_wdata_i);
        CFG_MAX_VALID:   max_valid_q   <= $signed(cfg_wdata_i);
        CFG_MIN_PIXELS:  min_pixels_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic                    in_acc;
  logic [1:0]              op_q;
  logic [COL_W-1:0]        col_q;
  logic signed [PIX_W-1:0] pix_q;
  logic                    pix_ok;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign pix_ok     = !in_i.pixel_special && (in_i.pixel >= min_valid_q)
                      && (in_i.pixel <= max_valid_q);

  // ram
  logic             ram_we, ram_re, rv_q;
  logic [COL_W-1:0] ram_waddr, ram_raddr, clr_q, mir_col;
  entry_t           ram_wdata, ram_rdata, upd;

  bmv_ram #(.Width(ENTRY_W), .Depth(MAX_SAMPLES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // window walk
  logic [3:0]  k_q;
  logic [4:0]  width_cnt;
  logic [LEN_W-1:0] len;
  logic signed [LEN_W+1:0] pos, lens;

  assign width_cnt = {1'b0, half_width_q, 1'b1};

  always_comb begin
    if (line_length_q == '0) begin
      len = LEN_W'(1);
    end else if (line_length_q > 12'(MAX_SAMPLES)) begin
      len = LEN_W'(MAX_SAMPLES);
    end else begin
      len = line_length_q;
    end
    lens = $signed({2'b00, len});
    pos  = $signed({3'b000, col_q}) - $signed({11'd0, half_width_q})
           + $signed({10'd0, k_q});
    if (pos < 0) begin
      pos = -pos;
    end
    if (pos >= lens) begin
      pos = lens + lens - (LEN_W+2)'(2) - pos;
    end
    if (pos < 0) begin
      pos = '0;
    end
    if (pos >= lens) begin
      pos = lens - (LEN_W+2)'(1);
    end
    mir_col = pos[COL_W-1:0];
  end

  // column update
  logic [SQ_W-1:0] pix_sq;
  assign pix_sq = SQ_W'($unsigned(32'(pix_q) * 32'(pix_q)));

  always_comb begin
    upd = ram_rdata;
    if (op_q == OP_ADD) begin
      upd.sum = ram_rdata.sum + SUM_W'(pix_q);
      upd.sq  = ram_rdata.sq + pix_sq;
      upd.cnt = ram_rdata.cnt + 1'b1;
    end else begin
      upd.sum = ram_rdata.sum - SUM_W'(pix_q);
      upd.sq  = ram_rdata.sq - pix_sq;
      upd.cnt = ram_rdata.cnt - 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_q;
    ram_wdata = upd;
    ram_re    = 1'b0;
    ram_raddr = mir_col;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = in_i.column;
        ram_re    = in_acc && pix_ok
                    && (in_i.operation == OP_ADD || in_i.operation == OP_REMOVE);
      end
      ST_UPD: ram_we = 1'b1;
      ST_ACC: ram_re = ({1'b0, k_q} < width_cnt);
      default: ;
    endcase
  end

  // window totals and statistics
  logic signed [WSUM_W-1:0]   s1_q;
  logic [WSQ_W-1:0]           s2_q;
  logic [WCNT_W-1:0]          n_q;
  logic [PROD_W-1:0]          prod_q;
  logic signed [2*WSUM_W-1:0] sq1_q;
  logic [WSUM_W-1:0]          mag;
  logic [7:0]                 area, need;
  logic                       avg_ok, var_ok;
  logic signed [PROD_W+1:0]   num;
  logic [DVS_W-1:0]           dsq;
  logic                       div_start, div_done;
  logic [DVD_W-1:0]           div_dvd, div_q;
  logic [DVS_W-1:0]           div_dvs;
  logic signed [WSUM_W-1:0]   avg_d;
  logic [VAR_W-1:0]           var_d;
  logic signed [WSUM_W-1:0]   avg_q;
  logic [VAR_W-1:0]           var_q;

  assign area   = 8'({half_width_q, 1'b1} * {half_height_q, 1'b1});
  assign need   = (min_pixels_q > area) ? area : min_pixels_q;
  assign avg_ok = (n_q >= need) && (n_q != '0);
  assign var_ok = avg_ok && (n_q > 8'd1);
  assign mag    = s1_q[WSUM_W-1] ? WSUM_W'(-s1_q) : s1_q;
  assign num    = $signed({2'b00, prod_q}) - $signed({sq1_q[2*WSUM_W-1], sq1_q});
  assign dsq    = DVS_W'(n_q * (n_q - 1'b1));

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVD_W'({mag, 8'd0}) + DVD_W'(n_q >> 1);
    div_dvs   = DVS_W'(n_q);
    if (state_q == ST_MUL) begin
      div_start = (k_q == 4'd7) && avg_ok;
    end else if (state_q == ST_DIVA) begin
      div_start = div_done && var_ok;
      div_dvs   = dsq;
      div_dvd   = (num < 0) ? '0
                  : DVD_W'({num[PROD_W-1:0], 8'd0}) + DVD_W'(dsq >> 1);
    end
  end

  bmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    if (s1_q[WSUM_W-1]) begin
      avg_d = (div_q > DVD_W'(24'd8388608)) ? AVG_LO : -$signed(div_q[WSUM_W-1:0]);
    end else begin
      avg_d = (div_q > DVD_W'(AVG_HI)) ? AVG_HI : $signed(div_q[WSUM_W-1:0]);
    end
    var_d = (div_q[DVD_W-1:VAR_W] != '0) ? '1 : div_q[VAR_W-1:0];
  end

  // control
  logic out_free;
  assign out_free = !out_o.valid || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      rv_q    <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      rv_q <= ram_re && (state_q == ST_ACC);
      if (state_q == ST_OUT && out_free) begin
        out_o.valid <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          k_q <= '0;
          if (ram_re) begin
            state_q <= ST_UPD;
          end else if (in_acc && in_i.operation == OP_QUERY) begin
            state_q <= ST_ACC;
          end
        end
        ST_UPD: state_q <= ST_IDLE;
        ST_ACC: begin
          if ({1'b0, k_q} == width_cnt) begin
            k_q     <= '0;
            state_q <= ST_MUL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_MUL: begin
          k_q <= k_q + 1'b1;
          if (k_q == 4'd7) begin
            state_q <= avg_ok ? ST_DIVA : ST_OUT;
          end
        end
        ST_DIVA: begin
          if (div_done) begin
            state_q <= var_ok ? ST_DIVV : ST_OUT;
          end
        end
        ST_DIVV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.operation;
      col_q <= in_i.column;
      pix_q <= in_i.pixel;
      s1_q  <= '0;
      s2_q  <= '0;
      n_q   <= '0;
    end
    if (state_q == ST_ACC && rv_q) begin
      s1_q <= s1_q + WSUM_W'($signed(ram_rdata.sum));
      s2_q <= s2_q + WSQ_W'(ram_rdata.sq);
      n_q  <= n_q + WCNT_W'(ram_rdata.cnt);
    end
    if (state_q == ST_ACC) begin
      prod_q <= '0;
    end
    if (state_q == ST_MUL) begin
      sq1_q <= s1_q * s1_q;
      if (n_q[k_q[2:0]]) begin
        prod_q <= prod_q + (PROD_W'(s2_q) << k_q[2:0]);
      end
    end
    if (state_q == ST_MUL && k_q == 4'd7) begin
      avg_q <= '0;
      var_q <= '0;
    end
    if (state_q == ST_DIVA && div_done) begin
      avg_q <= avg_d;
    end
    if (state_q == ST_DIVV && div_done) begin
      var_q <= var_d;
    end
    if (state_q == ST_OUT && out_free) begin
      out_o.valid_count <= n_q;
      out_o.average     <= avg_q;
      out_o.average_ok  <= avg_ok;
      out_o.variance    <= var_q;
      out_o.variance_ok <= var_ok;
    end
  end
endmodule

[rtl/bmv_checker.sv]
// port-level checks of the filter result channel, bound to the top level
// depends on bmv_pkg and assert_macros.svh
`include "assert_macros.svh"

module bmv_checker import bmv_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [WCNT_W-1:0]        valid_count_i,
  input logic signed [WSUM_W-1:0] average_i,
  input logic                     average_ok_i,
  input logic [VAR_W-1:0]         variance_i,
  input logic                     variance_ok_i
);
  `BMV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `BMV_ASSERT_NEVER(a_null_avg, clk_i, rst_ni, out_valid_i && !average_ok_i && average_i != '0)
  `BMV_ASSERT_NEVER(a_null_var, clk_i, rst_ni, out_valid_i && !variance_ok_i && variance_i != '0)
  `BMV_ASSERT_NEVER(a_var_cnt, clk_i, rst_ni,
                    out_valid_i && variance_ok_i && (!average_ok_i || valid_count_i < 8'd2))
endmodule

bind boxcar_mean_variance_filter bmv_checker u_bmv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .valid_count_i (out_o.valid_count),
  .average_i     (out_o.average),
  .average_ok_i  (out_o.average_ok),
  .variance_i    (out_o.variance),
  .variance_ok_i (out_o.variance_ok)
);
